// File: hw/rtl/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

   // operation codes carried by an input item
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;
   localparam logic [1:0] OP_ERASE  = 2'd3;

   // status codes returned with every result item
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // fixed field widths
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   // memory port strobes from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } pls_mem_cmd_type;

endpackage

// File: hw/rtl/pls_mem.sv
`timescale 1ns / 1ps

module pls_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                     clock,
   input  pls_pkg::pls_mem_cmd_type mem_cmd,
   input  logic [AW-1:0]            wr_addr,
   input  logic [31:0]              wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [31:0]              rd_data
);
   import pls_pkg::*;

   logic [VALUE_W-1:0] store_mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pls_seq.sv
`timescale 1ns / 1ps

module pls_seq #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [1:0]               in_opcode,
   input  logic [6:0]               in_position,
   input  logic [31:0]              in_value,
   output logic                     res_valid,
   input  logic                     res_ready,
   output logic [31:0]              res_popped,
   output logic [6:0]               res_count,
   output logic [1:0]               res_status,
   output pls_pkg::pls_mem_cmd_type mem_cmd,
   output logic [AW-1:0]            wr_addr,
   output logic [31:0]              wr_data,
   output logic [AW-1:0]            rd_addr,
   input  logic [31:0]              rd_data
);
   import pls_pkg::*;

   // common width for position and count compares
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_PUTV  = 3'd4;
   localparam logic [2:0] S_POPW  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]         st_ff, st_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [1:0]         op_ff, op_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] popped_ff, popped_in;
   logic [1:0]         status_ff, status_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      last_ff, last_in;
   logic [AW-1:0]      pw_ff, pw_in;
   logic               pend_ff, pend_in;

   logic [PW-1:0]      pos_ext;
   logic [PW-1:0]      cnt_ext;
   logic [CW-1:0]      cnt_dec;
   logic               full;
   logic               shift_up;

   assign pos_ext  = PW'(pos_ff);
   assign cnt_ext  = PW'(cnt_ff);
   assign cnt_dec  = cnt_ff - CW'(1);
   assign full     = (cnt_ff >= CW'(DEPTH));
   assign shift_up = (op_ff == OP_INSERT);

   // sequencer: one memory access pair per cycle
   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      pw_in     = pw_ff;
      pend_in   = pend_ff;
      mem_cmd   = '0;
      wr_addr   = pw_ff;
      wr_data   = rd_data;
      rd_addr   = cur_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (in_valid) begin
               op_in     = in_opcode;
               pos_in    = in_position;
               val_in    = in_value;
               popped_in = '0;
               status_in = ST_DONE;
               pend_in   = 1'b0;
               st_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in = S_RESP;
            unique case (op_ff)
               OP_PUSH: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_cmd.wr_en = 1'b1;
                     wr_addr       = cnt_ff[AW-1:0];
                     wr_data       = val_ff;
                     cnt_in        = cnt_ff + CW'(1);
                  end
               end
               OP_POP: begin
                  if (cnt_ff == '0) begin
                     status_in = ST_IGNORED;
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     rd_addr       = cnt_dec[AW-1:0];
                     cnt_in        = cnt_dec;
                     st_in         = S_POPW;
                  end
               end
               OP_INSERT: begin
                  if (pos_ext > cnt_ext) begin
                     status_in = ST_IGNORED;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                     if (pos_ext < cnt_ext) begin
                        cur_in  = cnt_dec[AW-1:0];
                        last_in = pos_ext[AW-1:0];
                        st_in   = S_SHIFT;
                     end else begin
                        st_in = S_PUTV;
                     end
                  end
               end
               default: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = ST_IGNORED;
                  end else begin
                     cnt_in = cnt_dec;
                     if (pos_ext < PW'(cnt_dec)) begin
                        cur_in  = pos_ext[AW-1:0] + AW'(1);
                        last_in = cnt_dec[AW-1:0];
                        st_in   = S_SHIFT;
                     end
                  end
               end
            endcase
         end
         // read one entry, write back the one read in the previous cycle
         S_SHIFT: begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.wr_en = pend_ff;
            pend_in       = 1'b1;
            pw_in         = shift_up ? cur_ff + AW'(1) : cur_ff - AW'(1);
            if (cur_ff == last_ff) begin
               st_in = S_DRAIN;
            end else begin
               cur_in = shift_up ? cur_ff - AW'(1) : cur_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            mem_cmd.wr_en = 1'b1;
            pend_in       = 1'b0;
            st_in         = shift_up ? S_PUTV : S_RESP;
         end
         S_PUTV: begin
            mem_cmd.wr_en = 1'b1;
            wr_addr       = pos_ext[AW-1:0];
            wr_data       = val_ff;
            st_in         = S_RESP;
         end
         S_POPW: begin
            popped_in = rd_data;
            st_in     = S_RESP;
         end
         S_RESP: begin
            if (res_ready) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   // item payload and shift cursors
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      pw_ff     <= pw_in;
   end

   assign in_ready   = (st_ff == S_IDLE);
   assign res_valid  = (st_ff == S_RESP);
   assign res_popped = popped_ff;
   assign res_count  = cnt_ext[COUNT_W-1:0];
   assign res_status = status_ff;

endmodule

// File: hw/rtl/positional_list_store_unit.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values held in one single-port-write,
// registered-read memory, with push, pop, insert at a position and erase at a
// position; every item returns one result carrying the popped value, the entry
// count (low 7 bits) and a status (done, ignored, dropped when full). Items are
// handled one at a time. Insert and erase shift the later entries up or down
// one entry per cycle, the read of the next entry overlapped with the write of
// the previous one. A finished result sits in an output register, so the next
// item is accepted while it waits. Entries at or above the count are never
// read; the memory needs no clearing after reset.

module positional_list_store_unit #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode[1:0], position[8:2], value[40:9], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // popped_value[31:0], element_count[38:32],
                                    // status[40:39], zero fill
);
   import pls_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pls_mem_cmd_type    mem_cmd;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [VALUE_W-1:0] rd_data;

   logic               res_valid;
   logic               res_ready;
   logic [VALUE_W-1:0] res_popped;
   logic [COUNT_W-1:0] res_count;
   logic [1:0]         res_status;

   logic               out_valid_ff, out_valid_in;
   logic [40:0]        out_data_ff, out_data_in;

   pls_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_opcode   (req_tdata[1:0]),
      .in_position (req_tdata[8:2]),
      .in_value    (req_tdata[40:9]),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_popped  (res_popped),
      .res_count   (res_count),
      .res_status  (res_status),
      .mem_cmd     (mem_cmd),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   pls_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register, loaded when empty or being drained
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_data_in  = {res_status, res_count, res_popped};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

endmodule
